// ===== hdl/glcm_pkg.sv =====
package glcm_pkg;

   localparam int FREQ_W = 16;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [2:0] LIST_PAIR  = 3'd0;
   localparam logic [2:0] LIST_SUM   = 3'd1;
   localparam logic [2:0] LIST_DIFF  = 3'd2;
   localparam logic [2:0] LIST_XMARG = 3'd3;
   localparam logic [2:0] LIST_YMARG = 3'd4;

   localparam logic [2:0] REG_SYMMETRIC = 3'd0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] ref_level;
      logic [15:0] nbr_level;
      logic [2:0]  list_select;
      logic [10:0] entry_index;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [16:0] key_first;
      logic [15:0] key_second;
      logic [15:0] frequency;
      logic [11:0] entry_count;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic commit;
   } list_ctl_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } list_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIR_SCAN,
      ST_AGG_SCAN,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/glcm_ram.sv =====
module glcm_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 32,
   parameter int AW    = 11
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/glcm_list.sv =====
module glcm_list
   import glcm_pkg::*;
#(
   parameter int MAX_ENTRIES = 2048,
   parameter int KEY_W       = 17,
   parameter int IDX_W       = 11,
   parameter int CNT_W       = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  list_ctl_type       ctl,
   input  logic [KEY_W-1:0]   key,
   input  logic [IDX_W-1:0]   rd_addr,
   output list_sts_type       sts,
   output logic [CNT_W-1:0]   count,
   output logic [KEY_W-1:0]   rd_key,
   output logic [FREQ_W-1:0]  rd_freq
);

   localparam int DW = KEY_W + FREQ_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_addr_ff, pend_addr_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_addr_ff, hit_addr_in;
   logic [FREQ_W-1:0] hit_freq_ff, hit_freq_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DW-1:0]     wr_data;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [DW-1:0]     mem_rd_data;
   logic              match, issue, full;

   glcm_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(DW), .AW(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_key  = mem_rd_data[DW-1:FREQ_W];
   assign rd_freq = mem_rd_data[FREQ_W-1:0];
   assign full    = (count_ff == CNT_W'(MAX_ENTRIES));
   // previous read compared against the key, next read issued behind it
   assign match   = pend_ff && (rd_key == key);
   assign issue   = scan_ff && !match && (ptr_ff < count_ff);
   assign mem_rd_addr = issue ? ptr_ff[IDX_W-1:0] : rd_addr;

   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      hit_addr_in  = hit_addr_ff;
      hit_freq_in  = hit_freq_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_addr_ff;
      wr_data      = {key, hit_freq_ff};

      if (ctl.start) begin
         ptr_in  = '0;
         scan_in = 1'b1;
         hit_in  = 1'b0;
      end else if (scan_ff) begin
         if (match) begin
            hit_in      = 1'b1;
            hit_addr_in = pend_addr_ff;
            hit_freq_in = rd_freq;
            scan_in     = 1'b0;
         end else if (issue) begin
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff[IDX_W-1:0];
            ptr_in       = ptr_ff + 1'b1;
         end else begin
            scan_in = 1'b0;
         end
      end

      if (ctl.commit) begin
         if (hit_ff) begin
            wr_en   = 1'b1;
            wr_data = {key, (hit_freq_ff == FREQ_MAX) ? FREQ_MAX : hit_freq_ff + 1'b1};
         end else if (!full) begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = {key, FREQ_W'(1)};
            count_in = count_ff + 1'b1;
         end
      end
      if (ctl.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         scan_ff  <= scan_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
      end
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      hit_addr_ff  <= hit_addr_in;
      hit_freq_ff  <= hit_freq_in;
   end

   assign sts.done = !scan_ff;
   assign sts.hit  = hit_ff;
   assign sts.full = full;
   assign count    = count_ff;

endmodule

// ===== hdl/sparse_glcm_pair_histogram.sv =====
// Channel   Ports            Direction  Moves
// request   req_*            in         one item: add pair, clear or read
// response  rsp_*            out        one item per request item
// csr       psel..pready     in/out     symmetric_mode register at byte 0
//
// Add: the pair list is scanned one entry per cycle from its memory port,
// then, unless the pair list is full and misses, the four aggregated lists
// are scanned in parallel; symmetric mode runs both passes twice.
// Reset clears counts, flags and state, not the list memories.
// A request is taken only between items; the response sits in an output
// register, and a stalled rsp_ready holds the next response back.
module sparse_glcm_pair_histogram
   import glcm_pkg::*;
#(
   parameter int MAX_ENTRIES = 2048,
   parameter int GRAY_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int AGG_W = GRAY_BITS + 1;
   localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;

   state_type st_ff, st_in;
   logic [GRAY_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic mirror_ff, mirror_in;
   logic read_ff, read_in;
   logic ovf_ff, ovf_in;
   logic sym_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in, res_ff, res_in;
   logic [2:0]  sel_ff;
   logic [10:0] idx_ff;

   list_ctl_type pair_ctl, agg_ctl;
   list_sts_type pair_sts;
   list_sts_type agg_sts [4];
   logic [CNT_W-1:0] cnt [5];
   logic [AGG_W-1:0] agg_key [4];
   logic [AGG_W-1:0] agg_rd_key [4];
   logic [FREQ_W-1:0] agg_rd_freq [4];
   logic [2*GRAY_BITS-1:0] pair_rd_key;
   logic [FREQ_W-1:0] pair_rd_freq;
   logic [IDX_W-1:0] rd_addr;
   logic agg_done, agg_ovf, req_fire, rsp_free;
   logic [CNT_W-1:0] sel_cnt;

   // config port
   assign pready = 1'b1;
   assign prdata = (paddr == REG_SYMMETRIC) ? {31'd0, sym_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b0;
      end else if (psel && penable && pwrite && (paddr == REG_SYMMETRIC)) begin
         sym_ff <= pwdata[0];
      end
   end

   // lists
   assign rd_addr = IDX_W'(req_data.entry_index);

   glcm_list #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_W(2*GRAY_BITS), .IDX_W(IDX_W),
      .CNT_W(CNT_W)) u_pair (
      .clock (clock), .reset (reset), .ctl (pair_ctl), .key ({a_ff, b_ff}),
      .rd_addr (rd_addr), .sts (pair_sts), .count (cnt[0]),
      .rd_key (pair_rd_key), .rd_freq (pair_rd_freq)
   );

   assign agg_key[0] = AGG_W'(a_ff) + AGG_W'(b_ff);
   assign agg_key[1] = (a_ff >= b_ff) ? AGG_W'(a_ff - b_ff) : AGG_W'(b_ff - a_ff);
   assign agg_key[2] = AGG_W'(a_ff);
   assign agg_key[3] = AGG_W'(b_ff);

   for (genvar g = 0; g < 4; g++) begin : g_agg
      glcm_list #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_W(AGG_W), .IDX_W(IDX_W),
         .CNT_W(CNT_W)) u_agg (
         .clock (clock), .reset (reset), .ctl (agg_ctl), .key (agg_key[g]),
         .rd_addr (rd_addr), .sts (agg_sts[g]), .count (cnt[g+1]),
         .rd_key (agg_rd_key[g]), .rd_freq (agg_rd_freq[g])
      );
   end

   assign agg_done = agg_sts[0].done && agg_sts[1].done && agg_sts[2].done
                     && agg_sts[3].done;
   assign agg_ovf  = (!agg_sts[0].hit && agg_sts[0].full) || (!agg_sts[1].hit && agg_sts[1].full)
                  || (!agg_sts[2].hit && agg_sts[2].full) || (!agg_sts[3].hit && agg_sts[3].full);

   assign req_ready = (st_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign sel_cnt   = (sel_ff <= LIST_YMARG) ? cnt[sel_ff] : '0;

   always_comb begin
      st_in        = st_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mirror_in    = mirror_ff;
      read_in      = read_ff;
      ovf_in       = ovf_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pair_ctl     = '0;
      agg_ctl      = '0;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               a_in      = req_data.ref_level[GRAY_BITS-1:0];
               b_in      = req_data.nbr_level[GRAY_BITS-1:0];
               mirror_in = 1'b0;
               read_in   = 1'b0;
               unique case (req_data.kind)
                  KIND_ADD: begin
                     pair_ctl.start = 1'b1;
                     st_in = ST_PAIR_SCAN;
                  end
                  KIND_CLEAR: begin
                     pair_ctl.clear = 1'b1;
                     agg_ctl.clear  = 1'b1;
                     ovf_in = 1'b0;
                     st_in  = ST_RESP;
                  end
                  KIND_READ: begin
                     read_in = 1'b1;
                     st_in   = ST_READ_WAIT;
                  end
                  default: st_in = ST_RESP;
               endcase
            end
         end
         ST_PAIR_SCAN: begin
            if (pair_sts.done) begin
               if (!pair_sts.hit && pair_sts.full) begin
                  ovf_in = 1'b1;
                  if (sym_ff && !mirror_ff) begin
                     a_in = b_ff; b_in = a_ff; mirror_in = 1'b1;
                     pair_ctl.start = 1'b1;
                  end else begin
                     st_in = ST_RESP;
                  end
               end else begin
                  pair_ctl.commit = 1'b1;
                  agg_ctl.start   = 1'b1;
                  st_in = ST_AGG_SCAN;
               end
            end
         end
         ST_AGG_SCAN: begin
            if (agg_done) begin
               agg_ctl.commit = 1'b1;
               ovf_in = ovf_ff || agg_ovf;
               if (sym_ff && !mirror_ff) begin
                  a_in = b_ff; b_in = a_ff; mirror_in = 1'b1;
                  pair_ctl.start = 1'b1;
                  st_in = ST_PAIR_SCAN;
               end else begin
                  st_in = ST_RESP;
               end
            end
         end
         ST_READ_WAIT: begin
            res_in = '0;
            res_in.entry_count = 12'(sel_cnt);
            if ((CMP_W'(idx_ff) < CMP_W'(sel_cnt))
                && (CMP_W'(idx_ff) < CMP_W'(MAX_ENTRIES))) begin
               res_in.entry_valid = 1'b1;
               if (sel_ff == LIST_PAIR) begin
                  res_in.key_first  = 17'(pair_rd_key[2*GRAY_BITS-1:GRAY_BITS]);
                  res_in.key_second = 16'(pair_rd_key[GRAY_BITS-1:0]);
                  res_in.frequency  = pair_rd_freq;
               end else begin
                  res_in.key_first  = 17'(agg_rd_key[sel_ff[1:0] - 2'd1]);
                  res_in.frequency  = agg_rd_freq[sel_ff[1:0] - 2'd1];
               end
            end
            st_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (read_ff) begin
                  rsp_in = res_ff;
               end else begin
                  rsp_in = '0;
                  rsp_in.entry_count = 12'(cnt[0]);
               end
               rsp_in.overflow = ovf_ff;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mirror_ff    <= 1'b0;
         read_ff      <= 1'b0;
      end else begin
         st_ff        <= st_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         mirror_ff    <= mirror_in;
         read_ff      <= read_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (req_fire) begin
         sel_ff <= req_data.list_select;
         idx_ff <= req_data.entry_index;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_RESP))
      else $error("response raised outside response state");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> (pair_sts.done && agg_done))
      else $error("list scan running while idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt[0] <= CNT_W'(MAX_ENTRIES))
      else $error("pair count above capacity");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import glcm_pkg::*;

   localparam int MAX_N    = 2048;
   localparam int LIMIT    = 2000000;
   localparam logic [2:0] CSR_SYM_ADDR = 3'(4 * REG_SYMMETRIC);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sparse_glcm_pair_histogram uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------
   // Histogram shadow: pair list plus the four aggregated lists.
   // Aggregated list a lives at hist_key[a] / hist_freq[a]; the pair
   // list keeps its two levels in pair_ref / pair_nbr.
   // ---------------------------------------------------------------
   logic [15:0] pair_ref  [MAX_N];
   logic [15:0] pair_nbr  [MAX_N];
   logic [15:0] pair_freq [MAX_N];
   logic [16:0] hist_key  [4][MAX_N];
   logic [15:0] hist_freq [4][MAX_N];
   int          list_len  [5];
   logic        ovf_flag;
   logic        sym_mode;

   rsp_type     expected_rsps[$];
   req_type     pending_reqs[$];
   int          errors;
   int          cycle_count;
   int          rsp_hold;     // long receiver hold-off request, in cycles

   function automatic logic [15:0] bump(input logic [15:0] f);
      return (f == FREQ_MAX) ? f : f + 16'd1;
   endfunction

   task automatic tally_key(input int lst, input logic [16:0] key);
      int p;
      for (p = 0; p < list_len[lst+1]; p++) begin
         if (hist_key[lst][p] == key) begin
            hist_freq[lst][p] = bump(hist_freq[lst][p]);
            return;
         end
      end
      if (list_len[lst+1] < MAX_N) begin
         hist_key[lst][list_len[lst+1]]  = key;
         hist_freq[lst][list_len[lst+1]] = 16'd1;
         list_len[lst+1]++;
      end else begin
         ovf_flag = 1'b1;
      end
   endtask

   task automatic tally_pair(input logic [15:0] a, input logic [15:0] b);
      int p;
      bit hit;
      hit = 0;
      for (p = 0; p < list_len[0]; p++) begin
         if (pair_ref[p] == a && pair_nbr[p] == b) begin
            pair_freq[p] = bump(pair_freq[p]);
            hit = 1;
            break;
         end
      end
      if (!hit) begin
         if (list_len[0] < MAX_N) begin
            pair_ref[list_len[0]]  = a;
            pair_nbr[list_len[0]]  = b;
            pair_freq[list_len[0]] = 16'd1;
            list_len[0]++;
         end else begin
            ovf_flag = 1'b1;
            return;
         end
      end
      tally_key(0, {1'b0, a} + {1'b0, b});
      tally_key(1, (a >= b) ? {1'b0, a - b} : {1'b0, b - a});
      tally_key(2, {1'b0, a});
      tally_key(3, {1'b0, b});
   endtask

   // Applies one accepted item to the shadow and queues its response.
   task automatic predict_histogram(input req_type r);
      rsp_type e;
      int sel;
      int idx;
      e = '0;
      if (r.kind == KIND_ADD) begin
         tally_pair(r.ref_level, r.nbr_level);
         if (sym_mode) tally_pair(r.nbr_level, r.ref_level);
      end else if (r.kind == KIND_CLEAR) begin
         foreach (list_len[k]) list_len[k] = 0;
         ovf_flag = 1'b0;
      end
      e.entry_count = 12'(list_len[0]);
      if (r.kind == KIND_READ) begin
         sel = r.list_select;
         idx = r.entry_index;
         e.entry_count = (sel <= 4) ? 12'(list_len[sel]) : 12'd0;
         if (sel <= 4 && idx < list_len[sel]) begin
            e.entry_valid = 1'b1;
            if (r.list_select == LIST_PAIR) begin
               e.key_first  = {1'b0, pair_ref[idx]};
               e.key_second = pair_nbr[idx];
               e.frequency  = pair_freq[idx];
            end else begin
               e.key_first = hist_key[sel-1][idx];
               e.frequency = hist_freq[sel-1][idx];
            end
         end
      end
      e.overflow = ovf_flag;
      expected_rsps.push_back(e);
   endtask

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("tb: mismatch %s got %0h want %0h at cycle %0d",
               what, got, want, cycle_count);
      errors++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // Driver: pops pending items; valid holds until the handshake.
   // ---------------------------------------------------------------
   int drv_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap   <= 0;
      end else if (req_valid && !req_ready) begin
         // hold item
      end else if (drv_gap > 0) begin
         req_valid <= 1'b0;
         drv_gap   <= drv_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         drv_gap   <= gap_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Predict on acceptance, sampled at the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) predict_histogram(req_data);
   end

   // Long receiver hold-off, counted down here.
   always @(posedge clock) begin
      if (rsp_hold > 0) rsp_hold <= rsp_hold - 1;
   end

   // ---------------------------------------------------------------
   // Monitor: random ready, plus the forced long hold-off.
   // ---------------------------------------------------------------
   int mon_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected item", 32'(rsp_data.entry_count), 0);
            end else begin
               rsp_type w;
               w = expected_rsps.pop_front();
               if (rsp_data.entry_valid !== w.entry_valid)
                  report("entry_valid", 32'(rsp_data.entry_valid), 32'(w.entry_valid));
               if (rsp_data.key_first !== w.key_first)
                  report("key_first", 32'(rsp_data.key_first), 32'(w.key_first));
               if (rsp_data.key_second !== w.key_second)
                  report("key_second", 32'(rsp_data.key_second), 32'(w.key_second));
               if (rsp_data.frequency !== w.frequency)
                  report("frequency", 32'(rsp_data.frequency), 32'(w.frequency));
               if (rsp_data.entry_count !== w.entry_count)
                  report("entry_count", 32'(rsp_data.entry_count), 32'(w.entry_count));
               if (rsp_data.overflow !== w.overflow)
                  report("overflow", 32'(rsp_data.overflow), 32'(w.overflow));
            end
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
         end else if (mon_gap > 0) begin
            rsp_ready <= 1'b0;
            mon_gap   <= mon_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            mon_gap   <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------
   task automatic queue_item(input logic [1:0] kind, input logic [15:0] a,
                             input logic [15:0] b, input logic [2:0] sel,
                             input logic [10:0] idx);
      req_type r;
      r.kind = kind; r.ref_level = a; r.nbr_level = b;
      r.list_select = sel; r.entry_index = idx;
      pending_reqs.push_back(r);
   endtask

   // Drain everything, then leave a quiet margin before a CSR write.
   // Checked mid-cycle so the driver's edge updates are settled.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_symmetric(input logic v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_SYM_ADDR; pwdata <= {31'd0, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      sym_mode = v;
   endtask

   // Mix of adds, mostly over a small level pool (so repeats hit), reads, and a few clears and unused kinds.
   task automatic random_phase(input int n);
      int i, c;
      logic [15:0] a, b;
      for (i = 0; i < n; i++) begin
         c = $urandom_range(0, 99);
         if ($urandom_range(0, 3) == 0) begin
            a = 16'($urandom); b = 16'($urandom);
         end else begin
            a = 16'($urandom_range(0, 5)); b = 16'($urandom_range(0, 5));
         end
         if (c < 55)
            queue_item(KIND_ADD, a, b, 3'($urandom), 11'($urandom));
         else if (c < 92)
            queue_item(KIND_READ, a, b, 3'($urandom_range(0, 5)),
                       11'($urandom_range(0, 12)));
         else if (c < 96)
            queue_item(KIND_READ, a, b, 3'($urandom), 11'($urandom));
         else if (c < 98)
            queue_item(KIND_CLEAR, a, b, 3'($urandom), 11'($urandom));
         else
            queue_item(2'd3, a, b, 3'($urandom), 11'($urandom));
      end
   endtask

   initial begin
      int k;
      errors = 0; cycle_count = 0; rsp_hold = 0;
      sym_mode = 1'b0; ovf_flag = 1'b0;
      foreach (list_len[k2]) list_len[k2] = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, asymmetric: extreme levels, equal levels, every list,
      // read past the end, unused select, unused kind, clear.
      write_symmetric(1'b0);
      queue_item(KIND_READ, 16'h0, 16'h0, LIST_PAIR, 11'd0);
      queue_item(KIND_ADD, 16'hFFFF, 16'h0000, 3'd7, 11'h7FF);
      queue_item(KIND_ADD, 16'h0000, 16'hFFFF, 3'd0, 11'd0);
      queue_item(KIND_ADD, 16'hFFFF, 16'hFFFF, 3'd0, 11'd0);
      queue_item(KIND_ADD, 16'hFFFF, 16'h0000, 3'd0, 11'd0);
      queue_item(KIND_ADD, 16'h1234, 16'h1234, 3'd0, 11'd0);
      for (k = 0; k < 5; k++) queue_item(KIND_READ, 16'h0, 16'h0, 3'(k), 11'd0);
      queue_item(KIND_READ, 16'h0, 16'h0, LIST_SUM, 11'd2);
      queue_item(KIND_READ, 16'h0, 16'h0, LIST_PAIR, 11'h7FF);
      queue_item(KIND_READ, 16'h0, 16'h0, 3'd5, 11'd0);
      queue_item(KIND_READ, 16'h0, 16'h0, 3'd7, 11'd1);
      queue_item(2'd3, 16'hFFFF, 16'hFFFF, 3'd7, 11'h7FF);
      queue_item(KIND_CLEAR, 16'h0, 16'h0, 3'd0, 11'd0);
      queue_item(KIND_READ, 16'h0, 16'h0, LIST_PAIR, 11'd0);
      drain();

      // Symmetric: equal levels count twice, mirrors fill in.
      write_symmetric(1'b1);
      queue_item(KIND_ADD, 16'd7, 16'd7, 3'd0, 11'd0);
      queue_item(KIND_ADD, 16'd2, 16'd9, 3'd0, 11'd0);
      for (k = 0; k < 5; k++) queue_item(KIND_READ, 16'h0, 16'h0, 3'(k), 11'd1);
      drain();

      // Long receiver hold-off while the sender keeps offering items.
      rsp_hold = 300;
      random_phase(40);
      drain();

      write_symmetric(1'b0);
      random_phase(50);
      drain();

      write_symmetric(1'b1);
      random_phase(40);
      drain();

      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
